### rtl/trapezoid_profile_generator_macros.svh
// ----------------------------------------------------------------------------
// Trapezoid profile generator assertion macros
// Shared concurrent assertion forms for the profile generator modules.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_PROFILE_GENERATOR_MACROS_SVH
`define TRAPEZOID_PROFILE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TPG_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tpg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TPG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tpg: next-cycle check failed");

`endif

### rtl/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Types, widths and command encodings shared by the profile generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int VW    = 24;  // Q8.16 velocity and acceleration
  localparam int TW    = 32;  // Q16.16 time
  localparam int PW    = 17;  // Q1.16 position
  localparam int PRODW = 56;  // multiplier product
  localparam int NUMW  = 56;  // divider numerator / root radicand
  localparam int DENW  = 48;  // divider denominator
  localparam int ROOTW = 28;  // root result
  localparam int CNTW  = 6;

  localparam logic [CNTW-1:0] DIV_STEPS  = 6'd56;
  localparam logic [CNTW-1:0] SQRT_STEPS = 6'd28;

  localparam logic [PW-1:0] POS_ONE  = 17'h10000;
  localparam logic [PW-1:0] POS_HALF = 17'h08000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    MA_LIMV, MA_LIMA, MA_ACCEL, MA_PEAK, MA_VT
  } ma_t;

  typedef enum logic [1:0] {
    MB_LIMV, MB_T, MB_TD, MB_FLAT
  } mb_t;

  typedef enum logic [2:0] {
    SRC_TA, SRC_AD, SRC_FLAT, SRC_TRI, SRC_SQ_Q, SRC_SQ_PK
  } src_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_TA_Q, ST_AD_Q, ST_FLAT_Q, ST_TA_ROOT, ST_PK_ROOT,
    ST_COMMIT_TRAP, ST_COMMIT_TRI
  } st_op_t;

  typedef enum logic [1:0] {
    TD_HOLD, TD_TA, TD_BASE
  } td_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_ZERO, ACC_ONE, ACC_P17, ACC_AD_P16, ACC_SUB_P17, ACC_ADD_P16
  } acc_op_t;

  typedef enum logic [2:0] {
    VEL_HOLD, VEL_ZERO, VEL_VT, VEL_PEAK, VEL_DECEL
  } vel_op_t;

  typedef struct packed {
    logic    latch_dt;
    ma_t     mul_a;
    mb_t     mul_b;
    logic    vv_load;
    logic    av_load;
    logic    unit_go;
    src_t    unit_src;
    st_op_t  st_op;
    td_op_t  td_op;
    logic    vt_load;
    acc_op_t acc_op;
    vel_op_t vel_op;
    logic    adv_time;
    logic    deact;
    logic    out_load;
    logic    res_status;
    logic    res_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic triangle;
    logic t_zero;
    logic t_ge_total;
    logic t_lt_ta;
    logic t_lt_taf;
    logic lim_zero;
    logic is_trap;
    logic busy;
  } dp_stat_t;

endpackage

### rtl/tpg_divsqrt.sv
// ----------------------------------------------------------------------------
// tpg_divsqrt
// Shared iterative unit: restoring divide (one quotient bit per cycle) or
// digit-by-digit square root (one root bit per cycle).
// ----------------------------------------------------------------------------
module tpg_divsqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic                      is_sqrt,
  input  logic [tpg_pkg::NUMW-1:0]  num,
  input  logic [tpg_pkg::DENW-1:0]  den,
  output logic                      busy,
  output logic [tpg_pkg::NUMW-1:0]  quot,
  output logic [tpg_pkg::ROOTW-1:0] root
);
  import tpg_pkg::*;

  logic [NUMW-1:0]  n;
  logic [DENW:0]    rem;
  logic [DENW-1:0]  den_r;
  logic [ROOTW-1:0] root_r;
  logic             mode;
  logic [CNTW-1:0]  cnt;

  logic [DENW:0]    shifted;
  logic [DENW+1:0]  diff;
  logic             ge;
  logic [30:0]      srem;
  logic [30:0]      trial;
  logic [31:0]      sdiff;
  logic             sge;

  always_comb begin
    shifted = {rem[DENW-1:0], n[NUMW-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = ~diff[DENW+1];
    srem    = {rem[28:0], n[NUMW-1:NUMW-2]};
    trial   = {1'b0, root_r, 2'b01};
    sdiff   = {1'b0, srem} - {1'b0, trial};
    sge     = ~sdiff[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      n      <= num;
      rem    <= '0;
      den_r  <= den;
      root_r <= '0;
      mode   <= is_sqrt;
      cnt    <= is_sqrt ? SQRT_STEPS : DIV_STEPS;
      busy   <= 1'b1;
    end else if (busy) begin
      if (mode) begin
        n      <= {n[NUMW-3:0], 2'b00};
        rem    <= sge ? {20'b0, sdiff[28:0]} : {18'b0, srem};
        root_r <= {root_r[ROOTW-2:0], sge};
      end else begin
        n   <= {n[NUMW-2:0], ge};
        rem <= ge ? diff[DENW:0] : shifted;
      end
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = n;
  assign root = root_r;

endmodule

### rtl/tpg_datapath.sv
// ----------------------------------------------------------------------------
// tpg_datapath
// Profile state, shared 24x32 multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
module tpg_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  tpg_pkg::dp_cmd_t       cmd,
  output tpg_pkg::dp_stat_t      stat,
  input  logic [tpg_pkg::VW-1:0] limv,
  input  logic [tpg_pkg::VW-1:0] lima,
  input  logic [tpg_pkg::TW-1:0] dt_in,
  output logic [47:0]            res_data,  // position[16:0], velocity[40:17]
  output logic [1:0]             res_user   // status[0], finished[1]
);
  import tpg_pkg::*;

  logic [TW-1:0]     elapsed, ta, flat, total, td, dt;
  logic [PW-1:0]     ad;
  logic [VW-1:0]     peak, accel, vt, vel_w;
  logic              triangle, active;
  logic [47:0]       vv, av;
  logic [PRODW-1:0]  p;
  logic signed [42:0] acc;
  logic [PW-1:0]     pos_r;
  logic [VW-1:0]     vel_r;
  logic              status_r, fin_r;

  logic [VW-1:0]     opa;
  logic [TW-1:0]     opb;
  logic [NUMW-1:0]   u_num;
  logic [DENW-1:0]   u_den;
  logic              u_sqrt, u_busy;
  logic [NUMW-1:0]   u_quot;
  logic [ROOTW-1:0]  u_root;
  logic [39:0]       flat_diff;
  logic [TW:0]       taf, tnext, base_diff;
  logic [33:0]       tsum;
  logic [PW-1:0]     pos_c;

  tpg_divsqrt u_unit (
    .clk     (clk),
    .rst     (rst),
    .go      (cmd.unit_go),
    .is_sqrt (u_sqrt),
    .num     (u_num),
    .den     (u_den),
    .busy    (u_busy),
    .quot    (u_quot),
    .root    (u_root)
  );

  always_comb begin
    case (cmd.mul_a)
      MA_LIMV:  opa = limv;
      MA_LIMA:  opa = lima;
      MA_ACCEL: opa = accel;
      MA_PEAK:  opa = peak;
      MA_VT:    opa = vt;
      default:  opa = '0;
    endcase
    case (cmd.mul_b)
      MB_LIMV: opb = {8'b0, limv};
      MB_T:    opb = elapsed;
      MB_TD:   opb = td;
      MB_FLAT: opb = flat;
      default: opb = '0;
    endcase
  end

  always_comb begin
    flat_diff = {lima, 16'b0} - vv[39:0];
    u_num  = '0;
    u_den  = '0;
    u_sqrt = 1'b0;
    case (cmd.unit_src)
      SRC_TA: begin
        u_num = {16'b0, limv, 16'b0};
        u_den = {24'b0, lima};
      end
      SRC_AD: begin
        u_num = {8'b0, vv};
        u_den = {23'b0, lima, 1'b0};
      end
      SRC_FLAT: begin
        u_num = {flat_diff, 16'b0};
        u_den = av;
      end
      SRC_TRI: begin
        u_num = 56'h01_0000_0000_0000;
        u_den = {24'b0, lima};
      end
      SRC_SQ_Q: begin
        u_num  = u_quot;
        u_sqrt = 1'b1;
      end
      SRC_SQ_PK: begin
        u_num  = {16'b0, lima, 16'b0};
        u_sqrt = 1'b1;
      end
      default: begin
        u_num = '0;
      end
    endcase
  end

  always_comb begin
    taf       = {1'b0, ta} + {1'b0, flat};
    tnext     = {1'b0, elapsed} + {1'b0, dt};
    base_diff = {1'b0, elapsed} - (triangle ? {1'b0, ta} : taf);
    tsum      = {1'b0, ta, 1'b0} + {2'b0, flat};
    if (acc[42]) begin
      pos_c = '0;
    end else if (acc > 43'sd65536) begin
      pos_c = POS_ONE;
    end else begin
      pos_c = acc[PW-1:0];
    end
  end

  always_comb begin
    stat.active     = active;
    stat.triangle   = triangle;
    stat.t_zero     = (elapsed == '0);
    stat.t_ge_total = (elapsed >= total);
    stat.t_lt_ta    = (elapsed < ta);
    stat.t_lt_taf   = ({1'b0, elapsed} < taf);
    stat.lim_zero   = (limv == '0) || (lima == '0);
    stat.is_trap    = (vv < {8'b0, lima, 16'b0});
    stat.busy       = u_busy;
  end

  // Profile state.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      ta       <= '0;
      flat     <= '0;
      total    <= '0;
      ad       <= '0;
      peak     <= '0;
      accel    <= '0;
      triangle <= 1'b0;
      active   <= 1'b0;
    end else begin
      case (cmd.st_op)
        ST_TA_Q:    ta   <= u_quot[TW-1:0];
        ST_AD_Q:    ad   <= u_quot[PW-1:0];
        ST_FLAT_Q:  flat <= (|u_quot[NUMW-1:TW]) ? '1 : u_quot[TW-1:0];
        ST_TA_ROOT: ta   <= {4'b0, u_root};
        ST_PK_ROOT: peak <= u_root[VW-1:0];
        ST_COMMIT_TRAP: begin
          peak     <= limv;
          total    <= (|tsum[33:32]) ? '1 : tsum[TW-1:0];
          triangle <= 1'b0;
          accel    <= lima;
          elapsed  <= '0;
          active   <= 1'b1;
        end
        ST_COMMIT_TRI: begin
          ad       <= POS_HALF;
          flat     <= '0;
          total    <= {ta[TW-2:0], 1'b0};
          triangle <= 1'b1;
          accel    <= lima;
          elapsed  <= '0;
          active   <= 1'b1;
        end
        default: begin
        end
      endcase
      if (cmd.adv_time) begin
        elapsed <= (tnext >= {1'b0, total}) ? total : tnext[TW-1:0];
      end
      if (cmd.deact) begin
        active <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    p <= PRODW'(opa) * PRODW'(opb);
    if (cmd.latch_dt) dt <= dt_in;
    if (cmd.vv_load) vv <= p[47:0];
    if (cmd.av_load) av <= p[47:0];
    // The running velocity stays below 2^24 for every reachable state.
    if (cmd.vt_load) vt <= p[39:16];
    case (cmd.td_op)
      TD_TA:   td <= elapsed - ta;
      TD_BASE: td <= base_diff[TW-1:0];
      default: begin
      end
    endcase
    case (cmd.acc_op)
      ACC_ZERO:    acc <= '0;
      ACC_ONE:     acc <= 43'sd65536;
      ACC_P17:     acc <= $signed({4'b0, p[PRODW-1:17]});
      ACC_AD_P16:  acc <= $signed({26'b0, ad}) + $signed({3'b0, p[PRODW-1:16]});
      ACC_SUB_P17: acc <= acc - $signed({4'b0, p[PRODW-1:17]});
      ACC_ADD_P16: acc <= acc + $signed({3'b0, p[PRODW-1:16]});
      default: begin
      end
    endcase
    case (cmd.vel_op)
      VEL_ZERO:  vel_w <= '0;
      VEL_VT:    vel_w <= vt;
      VEL_PEAK:  vel_w <= peak;
      VEL_DECEL: vel_w <= (peak > vt) ? (peak - vt) : '0;
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      pos_r    <= pos_c;
      vel_r    <= vel_w;
      status_r <= cmd.res_status;
      fin_r    <= cmd.res_fin;
    end
  end

  assign res_data = {7'b0, vel_r, pos_r};
  assign res_user = {fin_r, status_r};

endmodule

### rtl/tpg_ctrl.sv
// ----------------------------------------------------------------------------
// tpg_ctrl
// Sequencer: decodes each request and steps the datapath through the start
// derivation or the tick evaluation, then hands the result to the output.
// ----------------------------------------------------------------------------
`include "trapezoid_profile_generator_macros.svh"

module tpg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_opcode,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output tpg_pkg::dp_cmd_t  cmd,
  input  tpg_pkg::dp_stat_t stat
);
  import tpg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_ST_VV, S_ST_AV, S_ST_CLS,
    S_TR_TA, S_TR_TAW, S_TR_AD, S_TR_ADW, S_TR_FL, S_TR_FLW, S_TR_CM,
    S_TG_DIV, S_TG_DIVW, S_TG_SQW, S_TG_PKW, S_TG_CM,
    S_TA1, S_TA2, S_TA3, S_TA4,
    S_TF0, S_TF1, S_TF2,
    S_TD0, S_TD1, S_TD2, S_TD3, S_TD4, S_TD5,
    S_WB
  } state_t;

  state_t state, state_next;
  logic   opcode;
  logic   res_status, res_fin;
  logic   res_status_next, res_fin_next;
  logic   accept;
  logic   start_reject;

  assign s_tready     = (state == S_IDLE);
  assign accept       = s_tvalid && s_tready;
  assign start_reject = (state == S_DEC) && (opcode == OP_START) && stat.lim_zero;

  always_comb begin
    cmd = '0;
    cmd.res_status  = res_status;
    cmd.res_fin     = res_fin;
    cmd.latch_dt    = accept;
    state_next      = state;
    res_status_next = res_status;
    res_fin_next    = res_fin;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_DEC;
      end
      S_DEC: begin
        res_status_next = 1'b0;
        res_fin_next    = 1'b0;
        if (opcode == OP_START) begin
          cmd.acc_op = ACC_ZERO;
          cmd.vel_op = VEL_ZERO;
          if (stat.lim_zero) begin
            res_status_next = 1'b1;
            res_fin_next    = ~stat.active;
            state_next      = S_WB;
          end else begin
            state_next = S_ST_VV;
          end
        end else if (!stat.active) begin
          cmd.acc_op   = ACC_ONE;
          cmd.vel_op   = VEL_ZERO;
          res_fin_next = 1'b1;
          state_next   = S_WB;
        end else if (stat.t_ge_total && !stat.t_zero) begin
          cmd.acc_op   = ACC_ONE;
          cmd.vel_op   = VEL_ZERO;
          cmd.deact    = 1'b1;
          res_fin_next = 1'b1;
          state_next   = S_WB;
        end else if (stat.t_zero) begin
          cmd.acc_op   = ACC_ZERO;
          cmd.vel_op   = VEL_ZERO;
          cmd.adv_time = 1'b1;
          state_next   = S_WB;
        end else if (stat.t_lt_ta) begin
          state_next = S_TA1;
        end else if (!stat.triangle && stat.t_lt_taf) begin
          state_next = S_TF0;
        end else begin
          state_next = S_TD0;
        end
      end
      S_ST_VV: begin
        cmd.mul_a  = MA_LIMV;
        cmd.mul_b  = MB_LIMV;
        state_next = S_ST_AV;
      end
      S_ST_AV: begin
        cmd.vv_load = 1'b1;
        cmd.mul_a   = MA_LIMA;
        cmd.mul_b   = MB_LIMV;
        state_next  = S_ST_CLS;
      end
      S_ST_CLS: begin
        cmd.av_load = 1'b1;
        state_next  = stat.is_trap ? S_TR_TA : S_TG_DIV;
      end
      S_TR_TA: begin
        cmd.unit_go  = 1'b1;
        cmd.unit_src = SRC_TA;
        state_next   = S_TR_TAW;
      end
      S_TR_TAW: begin
        if (!stat.busy) begin
          cmd.st_op  = ST_TA_Q;
          state_next = S_TR_AD;
        end
      end
      S_TR_AD: begin
        cmd.unit_go  = 1'b1;
        cmd.unit_src = SRC_AD;
        state_next   = S_TR_ADW;
      end
      S_TR_ADW: begin
        if (!stat.busy) begin
          cmd.st_op  = ST_AD_Q;
          state_next = S_TR_FL;
        end
      end
      S_TR_FL: begin
        cmd.unit_go  = 1'b1;
        cmd.unit_src = SRC_FLAT;
        state_next   = S_TR_FLW;
      end
      S_TR_FLW: begin
        if (!stat.busy) begin
          cmd.st_op  = ST_FLAT_Q;
          state_next = S_TR_CM;
        end
      end
      S_TR_CM: begin
        cmd.st_op  = ST_COMMIT_TRAP;
        state_next = S_WB;
      end
      S_TG_DIV: begin
        cmd.unit_go  = 1'b1;
        cmd.unit_src = SRC_TRI;
        state_next   = S_TG_DIVW;
      end
      S_TG_DIVW: begin
        // The quotient feeds straight back in as the radicand.
        if (!stat.busy) begin
          cmd.unit_go  = 1'b1;
          cmd.unit_src = SRC_SQ_Q;
          state_next   = S_TG_SQW;
        end
      end
      S_TG_SQW: begin
        if (!stat.busy) begin
          cmd.st_op    = ST_TA_ROOT;
          cmd.unit_go  = 1'b1;
          cmd.unit_src = SRC_SQ_PK;
          state_next   = S_TG_PKW;
        end
      end
      S_TG_PKW: begin
        if (!stat.busy) begin
          cmd.st_op  = ST_PK_ROOT;
          state_next = S_TG_CM;
        end
      end
      S_TG_CM: begin
        cmd.st_op  = ST_COMMIT_TRI;
        state_next = S_WB;
      end
      S_TA1: begin
        cmd.mul_a  = MA_ACCEL;
        cmd.mul_b  = MB_T;
        state_next = S_TA2;
      end
      S_TA2: begin
        cmd.vt_load = 1'b1;
        state_next  = S_TA3;
      end
      S_TA3: begin
        cmd.mul_a  = MA_VT;
        cmd.mul_b  = MB_T;
        state_next = S_TA4;
      end
      S_TA4: begin
        cmd.acc_op   = ACC_P17;
        cmd.vel_op   = VEL_VT;
        cmd.adv_time = 1'b1;
        state_next   = S_WB;
      end
      S_TF0: begin
        cmd.td_op  = TD_TA;
        state_next = S_TF1;
      end
      S_TF1: begin
        cmd.mul_a  = MA_PEAK;
        cmd.mul_b  = MB_TD;
        state_next = S_TF2;
      end
      S_TF2: begin
        cmd.acc_op   = ACC_AD_P16;
        cmd.vel_op   = VEL_PEAK;
        cmd.adv_time = 1'b1;
        state_next   = S_WB;
      end
      S_TD0: begin
        cmd.td_op  = TD_BASE;
        state_next = S_TD1;
      end
      S_TD1: begin
        cmd.mul_a  = MA_ACCEL;
        cmd.mul_b  = MB_TD;
        state_next = S_TD2;
      end
      S_TD2: begin
        cmd.vt_load = 1'b1;
        cmd.mul_a   = MA_PEAK;
        cmd.mul_b   = MB_TD;
        state_next  = S_TD3;
      end
      S_TD3: begin
        cmd.acc_op = ACC_AD_P16;
        cmd.mul_a  = MA_VT;
        cmd.mul_b  = MB_TD;
        state_next = S_TD4;
      end
      S_TD4: begin
        cmd.acc_op = ACC_SUB_P17;
        cmd.mul_a  = MA_PEAK;
        cmd.mul_b  = MB_FLAT;
        state_next = S_TD5;
      end
      S_TD5: begin
        if (!stat.triangle) cmd.acc_op = ACC_ADD_P16;
        cmd.vel_op   = VEL_DECEL;
        cmd.adv_time = 1'b1;
        state_next   = S_WB;
      end
      S_WB: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      opcode     <= OP_START;
      res_status <= 1'b0;
      res_fin    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_fin    <= res_fin_next;
      if (accept) opcode <= s_opcode;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `TPG_ASSERT_IMPL(a_go_when_free, clk, rst, cmd.unit_go, !stat.busy)
  `TPG_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_load, !m_tvalid || m_tready)
  `TPG_ASSERT_NEXT(a_reject_flag, clk, rst, start_reject, res_status)

endmodule

### rtl/trapezoid_profile_generator.sv
// ----------------------------------------------------------------------------
// trapezoid_profile_generator
// Normalized trapezoidal / triangular motion profile over unit distance.
//
// Requests enter on the s_ stream: s_tuser selects start (0) or tick (1),
// s_tdata carries the tick duration in Q16.16. Every request yields exactly
// one result on the m_ stream: position Q1.16 and velocity Q8.16 in m_tdata,
// status and finished in m_tuser. The limits are written over the APB port
// at address 0 (velocity) and 4 (acceleration); the user must write them only
// while no request is in flight, and the block itself does not enforce this.
// One request is worked at a time. A trapezoid start runs three 56-step
// divides in the shared divide/root unit and a triangle start one divide and
// two 28-step roots. A tick answers directly when inactive, finished or at
// time zero, and otherwise evaluates the accelerating, flat or decelerating
// segment. s_tready returns in the cycle after the result is loaded. A
// stalled receiver holds the result and only delays the following one.
// Reset clears the profile to inactive and sets both limits to 1.0.
// ----------------------------------------------------------------------------
module trapezoid_profile_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // time_step[31:0]
  input  logic        s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // position[16:0], velocity[40:17], zero pad
  output logic [1:0]  m_tuser,   // status[0], finished[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tpg_pkg::*;

  logic [VW-1:0] velocity_limit, accel_limit;
  dp_cmd_t       cmd;
  dp_stat_t      stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_limit <= 24'h010000;
      accel_limit    <= 24'h010000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        accel_limit <= pwdata[VW-1:0];
      end else begin
        velocity_limit <= pwdata[VW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {8'b0, accel_limit} : {8'b0, velocity_limit};

  tpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_opcode (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tpg_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .limv     (velocity_limit),
    .lima     (accel_limit),
    .dt_in    (s_tdata),
    .res_data (m_tdata),
    .res_user (m_tuser)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trapezoid profile generator regression
// Drives start and tick requests on the input stream and checks every
// profile sample against a behavioral predictor of the same fixed point
// arithmetic. The limits are changed over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import tpg_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] dt;
  } req_t;

  typedef struct packed {
    logic [16:0] pos;
    logic [23:0] vel;
    logic        status;
    logic        fin;
  } sample_t;

  localparam logic [2:0] ADDR_VLIM = 3'd0;
  localparam logic [2:0] ADDR_ALIM = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trapezoid_profile_generator uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Profile state of the predictor.
  logic [23:0] vlim, alim, lat_a, peak_v;
  logic [31:0] t_el, t_acc, t_flat, t_total;
  logic [16:0] d_acc;
  logic        tri_mode, active;

  req_t    pending_reqs[$];
  sample_t expected_samples[$];
  int      fails = 0;
  int      send_idle = 24, recv_idle = 52;
  bit      hold_send = 1'b0;
  bit      in_taken = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic sample_t predict_sample(req_t r);
    sample_t s;
    logic [63:0] v, a, t, ta, taf, base, td, dv, vel, q;
    longint pos, sv;
    s = '0;
    pos = 0;
    sv = 0;
    if (r.op == OP_START) begin
      v = 64'(vlim);
      a = 64'(alim);
      if (v == 0 || a == 0) begin
        s.status = 1'b1;
        s.fin = !active;
      end else begin
        lat_a = a[23:0];
        t_el = 0;
        active = 1'b1;
        if (v * v < (a << 16)) begin
          q = (((a << 16) - v * v) << 16) / (a * v);
          tri_mode = 1'b0;
          t_acc = 32'((v << 16) / a);
          d_acc = 17'((v * v) / (2 * a));
          peak_v = v[23:0];
          t_flat = clip32(q);
          t_total = clip32(2 * 64'(t_acc) + 64'(t_flat));
        end else begin
          tri_mode = 1'b1;
          t_acc = 32'(int_sqrt((64'd1 << 48) / a));
          d_acc = POS_HALF;
          peak_v = 24'(int_sqrt(a << 16));
          t_flat = 0;
          t_total = 32'(2 * 64'(t_acc));
        end
      end
      return s;
    end
    if (!active) begin
      s.pos = POS_ONE;
      s.fin = 1'b1;
      return s;
    end
    t = 64'(t_el);
    a = 64'(lat_a);
    ta = 64'(t_acc);
    taf = ta + 64'(t_flat);
    if (t >= 64'(t_total) && t != 0) begin
      s.pos = POS_ONE;
      s.fin = 1'b1;
      active = 1'b0;
      return s;
    end
    if (t == 0) begin
      pos = 0;
    end else if (t < ta) begin
      vel = (a * t) >> 16;
      sv = vel;
      pos = (vel * t) >> 17;
    end else if (!tri_mode && t < taf) begin
      sv = peak_v;
      pos = d_acc + ((64'(peak_v) * (t - ta)) >> 16);
    end else begin
      base = tri_mode ? ta : taf;
      td = t - base;
      dv = (a * td) >> 16;
      pos = longint'(d_acc) + longint'((64'(peak_v) * td) >> 16)
            - longint'((dv * td) >> 17);
      if (!tri_mode) pos += longint'((64'(peak_v) * 64'(t_flat)) >> 16);
      sv = longint'(peak_v) - longint'(dv);
    end
    if (pos < 0) pos = 0;
    if (pos > 65536) pos = 65536;
    if (sv < 0) sv = 0;
    s.pos = pos[16:0];
    s.vel = sv[23:0];
    t += 64'(r.dt);
    if (t >= 64'(t_total)) t = 64'(t_total);
    t_el = t[31:0];
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // A request is taken at a rising edge where valid and ready are both high;
  // the prediction is made there and the driver learns of it at the next
  // falling edge.
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_samples.push_back(predict_sample({s_tuser, s_tdata}));
    end
  end

  // Driver: a new request goes out once the line is free.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          req_t r;
          r = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.op;
          s_tdata <= r.dt;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Results are checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sample_t got, want;
      got.pos = m_tdata[16:0];
      got.vel = m_tdata[40:17];
      got.status = m_tuser[0];
      got.fin = m_tuser[1];
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = expected_samples.pop_front();
        if (got.pos != want.pos) report_mismatch("position", got.pos, want.pos);
        if (got.vel != want.vel) report_mismatch("velocity", got.vel, want.vel);
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.fin != want.fin) report_mismatch("finished", got.fin, want.fin);
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_tvalid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_VLIM) vlim = data[23:0];
    else if (addr == ADDR_ALIM) alim = data[23:0];
    @(negedge clk);
  endtask

  task automatic set_limits(logic [31:0] v, logic [31:0] a);
    wait_drained();
    apb_write(ADDR_VLIM, v);
    apb_write(ADDR_ALIM, a);
  endtask

  task automatic push(logic op, logic [31:0] dt);
    pending_reqs.push_back('{op: op, dt: dt});
  endtask

  // A well-formed profile: a start followed by n ticks of random step.
  task automatic push_profile(int n);
    logic [31:0] step;
    step = 32'd1 << $urandom_range(10, 17);
    push(OP_START, $urandom);
    for (int i = 0; i < n; i++)
      push(OP_TICK, ($urandom_range(9) == 0) ? $urandom : $urandom_range(step));
  endtask

  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) == 0) begin
        push(1'($urandom_range(1)), $urandom);
        k++;
      end else begin
        int m;
        m = $urandom_range(4, 16);
        push_profile(m);
        k += m + 1;
      end
    end
  endtask

  initial begin
    vlim = 24'h010000;
    alim = 24'h010000;
    lat_a = 0; peak_v = 0; t_el = 0; t_acc = 0; t_flat = 0; t_total = 0;
    d_acc = 0; tri_mode = 0; active = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: inactive tick, reset limits, extremes, rejected starts.
    push(OP_TICK, 32'hFFFF_FFFF);
    push(OP_START, 0);
    push(OP_TICK, 0);
    push(OP_TICK, 32'h0000_8000);
    push(OP_TICK, 32'h0001_0000);
    push(OP_TICK, 32'hFFFF_FFFF);
    push(OP_TICK, 32'd1);
    push(OP_TICK, 32'd1);
    set_limits(0, 32'h00FF_FFFF);
    push(OP_START, 0);
    push(OP_TICK, 32'h0000_4000);
    set_limits(32'h00FF_FFFF, 0);
    push(OP_START, 0);
    set_limits(32'd1, 32'h00FF_FFFF);
    push(OP_START, 0);
    push(OP_TICK, 32'h0100_0000);
    push(OP_TICK, 32'hFFFF_FFFF);
    push(OP_TICK, 0);
    set_limits(32'hFFFF_FFFF, 32'd1);
    push(OP_START, 0);
    push(OP_TICK, 32'h7FFF_FFFF);
    push(OP_TICK, 32'h8000_0000);
    push(OP_TICK, 32'hFFFF_FFFF);
    push(OP_TICK, 0);
    set_limits(32'h0000_8000, 32'h0002_0000);
    push(OP_START, 32'hFFFF_FFFF);
    wait_drained();

    // Hold the driver back while a profile is queued, then release it.
    hold_send = 1'b1;
    push_profile(6);
    repeat (50) @(negedge clk);
    hold_send = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 52; recv_idle = 24; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      case (ph % 3)
        0: set_limits($urandom_range(32'h4000, 32'h40000), $urandom_range(32'h4000, 32'h40000));
        1: set_limits($urandom, $urandom);
        default: set_limits($urandom_range(1, 32'h100), $urandom_range(1, 32'h00FF_FFFF));
      endcase
      random_phase(85);
    end
    wait_drained();
    if (fails == 0) begin
      $display("trapezoid_profile_generator regression: pass");
    end else begin
      $display("trapezoid_profile_generator regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("trapezoid_profile_generator regression: fail");
    $finish;
  end
endmodule
